// ===== hw/rtl/c2dvw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2dvw_pkg: shared types and constants of the valid-window 2D convolution
// Holds command and register index codes, fixed field widths, the saturation
// limits of the 48-bit accumulator and the result side-band record.
// ----------------------------------------------------------------------------
package c2dvw_pkg;

    // Fixed field widths.
    localparam int ACC_BITS      = 48;
    localparam int ROW_BITS      = 16;
    localparam int COL_BITS      = 8;
    localparam int WIDX_BITS     = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register defaults after reset.
    localparam int RST_IN_WIDTH    = 256;
    localparam int RST_IN_HEIGHT   = 256;
    localparam int RST_KERN_HEIGHT = 3;
    localparam int RST_KERN_WIDTH  = 3;
    localparam int MAX_HEIGHT      = 65535;

    // Saturation limits of the result.
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // Input command codes.
    typedef enum logic [0:0] {
        CMD_LOAD_WEIGHT = 1'b0,
        CMD_SAMPLE      = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IN_WIDTH    = 2'd0,
        CFG_IN_HEIGHT   = 2'd1,
        CFG_KERN_HEIGHT = 2'd2,
        CFG_KERN_WIDTH  = 2'd3
    } t_cfg_idx;

    // Side-band data that travels with a window through the pipeline.
    typedef struct packed {
        logic signed [ACC_BITS-1:0] psum;
        logic [ROW_BITS-1:0]        row;
        logic [COL_BITS-1:0]        col;
        logic                       last;
    } t_meta;

endpackage

// ===== hw/rtl/c2dvw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2dvw_in_if: input channel of the valid-window 2D convolution
// Carries weight loads and samples with their partial sums, valid/ready.
// ----------------------------------------------------------------------------
interface c2dvw_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                        valid;
    logic                                        ready;
    logic                                        cmd;
    logic [c2dvw_pkg::WIDX_BITS-1:0]             weight_index;
    logic signed [SAMPLE_BITS-1:0]               weight_value;
    logic signed [SAMPLE_BITS-1:0]               sample;
    logic signed [c2dvw_pkg::ACC_BITS-1:0]       partial_sum;

    modport source (
        output valid, cmd, weight_index, weight_value, sample, partial_sum,
        input  ready
    );

    modport sink (
        input  valid, cmd, weight_index, weight_value, sample, partial_sum,
        output ready
    );
endinterface

// ===== hw/rtl/c2dvw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2dvw_out_if: result channel of the valid-window 2D convolution
// Carries the saturated window sum with its output position, valid/ready.
// ----------------------------------------------------------------------------
interface c2dvw_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [c2dvw_pkg::ACC_BITS-1:0] out_value;
    logic [c2dvw_pkg::ROW_BITS-1:0]        out_row;
    logic [c2dvw_pkg::COL_BITS-1:0]        out_col;
    logic                                  last;

    modport source (
        output valid, out_value, out_row, out_col, last,
        input  ready
    );

    modport sink (
        input  valid, out_value, out_row, out_col, last,
        output ready
    );
endinterface

// ===== hw/rtl/conv2d_valid_window_top.sv =====
`timescale 1ns / 1ps
// A sample that completes a window passes stage 1, stages 2 to 5 and the output register before its result shows.
// Throughput: one transaction per cycle; the pipeline stalls only when full and blocked.
// The line memory is read once and written once per sample at its column address.
// Reset clears the stream counters and pipeline valids and loads the geometry registers with their defaults.
// Kernel weights and the line memory are not cleared; they are defined once written.
// ----------------------------------------------------------------------------
// conv2d_valid_window_top: valid-mode 2D cross-correlation with line buffers
// Streams row-major samples through a column-indexed line memory and a window
// of registers, multiplies the window by the kernel, adds the incoming partial
// sum and saturates to 48 bits.
// ----------------------------------------------------------------------------
module conv2d_valid_window_top #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_KERNEL  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [c2dvw_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [c2dvw_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    c2dvw_in_if.sink                               i_in,
    c2dvw_out_if.source                            o_out
);

    localparam int K   = MAX_KERNEL;
    localparam int SB  = SAMPLE_BITS;
    localparam int LS  = (K > 1) ? K - 1 : 1;
    localparam int LW  = LS * SB;
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int KB  = $clog2(K + 1);
    localparam int KN  = K * K;
    localparam int KIW = (KN > 1) ? $clog2(KN) : 1;
    localparam int PW  = 2 * SB;
    localparam int RW  = PW + $clog2(K);
    localparam int TW0 = PW + $clog2(KN);
    localparam int AW  = ((c2dvw_pkg::ACC_BITS > TW0) ? c2dvw_pkg::ACC_BITS : TW0) + 1;

    // Maps a register value of zero to one and caps it at the given limit.
    function automatic int clamp_cfg(input int v, input int hi);
        int r;
        r = (v == 0) ? 1 : ((v > hi) ? hi : v);
        return r;
    endfunction

    // Effective geometry and stream position.
    logic [WW-1:0]                   r_w_eff;
    logic [15:0]                     r_h_eff;
    logic [KB-1:0]                   r_kh_eff;
    logic [KB-1:0]                   r_kw_eff;
    logic [15:0]                     r_row;
    logic [CW-1:0]                   r_col;
    logic [15:0]                     n_row;
    logic [CW-1:0]                   n_col;

    // Pipeline handshake.
    logic ld1, ld2, ld3, ld4, ld5, ldo;
    logic in_acc, sample_acc, s1_out, s1_is_sample;
    logic acc_emit, acc_last;

    // Stage 1: accepted transaction and line memory word.
    logic                            r_v1;
    logic                            r_s1_cmd;
    logic [c2dvw_pkg::WIDX_BITS-1:0] r_s1_widx;
    logic signed [SB-1:0]            r_s1_wval;
    logic signed [SB-1:0]            r_s1_sample;
    logic [CW-1:0]                   r_s1_colidx;
    logic                            r_s1_emit;
    c2dvw_pkg::t_meta                r_s1_meta;
    logic [LW-1:0]                   r_line [MAX_WIDTH];
    logic [LW-1:0]                   r_mem_q;
    logic                            r_byp_v;
    logic [LW-1:0]                   r_byp_word;
    logic [LW-1:0]                   s1_word;
    logic [LW-1:0]                   s1_new_word;
    logic signed [SB-1:0]            s1_colv [K];

    // Stage 2: window, kernel and per-position weights.
    logic signed [SB-1:0]            r_win  [K][K];
    logic signed [SB-1:0]            r_kern [KN];
    logic signed [SB-1:0]            r_lane [K][K];
    logic signed [SB-1:0]            n_lane [K][K];
    logic                            r_v2;
    c2dvw_pkg::t_meta                r_s2_meta;

    // Stage 3 to 5: products, row sums and total.
    logic                            r_v3, r_v4, r_v5;
    logic signed [PW-1:0]            r_prod [K][K];
    c2dvw_pkg::t_meta                r_s3_meta;
    logic signed [RW-1:0]            r_rsum [K];
    logic signed [RW-1:0]            n_rsum [K];
    c2dvw_pkg::t_meta                r_s4_meta;
    logic signed [AW-1:0]            r_total;
    logic signed [AW-1:0]            n_total;
    c2dvw_pkg::t_meta                r_s5_meta;

    // Output register.
    logic                                  r_vo;
    logic signed [c2dvw_pkg::ACC_BITS-1:0] r_o_value;
    logic signed [c2dvw_pkg::ACC_BITS-1:0] n_o_value;
    c2dvw_pkg::t_meta                      r_o_meta;

    // Each stage loads when it is empty or its content moves on.
    assign ldo = !r_vo || o_out.ready;
    assign ld5 = !r_v5 || ldo;
    assign ld4 = !r_v4 || ld5;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign i_in.ready   = ld1;
    assign in_acc       = i_in.valid && ld1;
    assign sample_acc   = in_acc && (i_in.cmd == c2dvw_pkg::CMD_SAMPLE);
    assign s1_is_sample = (r_s1_cmd == c2dvw_pkg::CMD_SAMPLE);
    assign s1_out       = r_v1 && ld2;

    // Window completion, last flag and next stream position.
    always_comb begin
        acc_emit = (32'(r_kh_eff) <= 32'(r_h_eff)) && (32'(r_kw_eff) <= 32'(r_w_eff))
                && (32'(r_row) + 1 >= 32'(r_kh_eff)) && (32'(r_col) + 1 >= 32'(r_kw_eff));
        acc_last = (32'(r_row) + 1 == 32'(r_h_eff)) && (32'(r_col) + 1 == 32'(r_w_eff));
        n_row = r_row;
        n_col = r_col;
        if (sample_acc) begin
            if (32'(r_col) + 1 >= 32'(r_w_eff)) begin
                n_col = '0;
                n_row = (32'(r_row) + 1 >= 32'(r_h_eff)) ? '0 : r_row + 16'd1;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // Geometry registers; any write restarts the tile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff  <= WW'(clamp_cfg(c2dvw_pkg::RST_IN_WIDTH, MAX_WIDTH));
            r_h_eff  <= 16'(clamp_cfg(c2dvw_pkg::RST_IN_HEIGHT, c2dvw_pkg::MAX_HEIGHT));
            r_kh_eff <= KB'(clamp_cfg(c2dvw_pkg::RST_KERN_HEIGHT, K));
            r_kw_eff <= KB'(clamp_cfg(c2dvw_pkg::RST_KERN_WIDTH, K));
            r_row    <= '0;
            r_col    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                c2dvw_pkg::CFG_IN_WIDTH: begin
                    r_w_eff <= WW'(clamp_cfg(int'(i_cfg_wdata[8:0]), MAX_WIDTH));
                end
                c2dvw_pkg::CFG_IN_HEIGHT: begin
                    r_h_eff <= 16'(clamp_cfg(int'(i_cfg_wdata), c2dvw_pkg::MAX_HEIGHT));
                end
                c2dvw_pkg::CFG_KERN_HEIGHT: begin
                    r_kh_eff <= KB'(clamp_cfg(int'(i_cfg_wdata[2:0]), K));
                end
                c2dvw_pkg::CFG_KERN_WIDTH: begin
                    r_kw_eff <= KB'(clamp_cfg(int'(i_cfg_wdata[2:0]), K));
                end
                default: begin
                end
            endcase
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Stage 1 capture of the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ld1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_cmd       <= i_in.cmd;
            r_s1_widx      <= i_in.weight_index;
            r_s1_wval      <= i_in.weight_value;
            r_s1_sample    <= i_in.sample;
            r_s1_colidx    <= r_col;
            r_s1_emit      <= acc_emit;
            r_s1_meta.psum <= i_in.partial_sum;
            r_s1_meta.row  <= 16'(32'(r_row) - 32'(r_kh_eff) + 1);
            r_s1_meta.col  <= 8'(32'(r_col) - 32'(r_kw_eff) + 1);
            r_s1_meta.last <= acc_last;
        end
    end

    // Line memory: one word per column holds the previous rows, newest first.
    always_ff @(posedge i_clk) begin
        if (s1_out && s1_is_sample) begin
            r_line[r_s1_colidx] <= s1_new_word;
        end
        if (in_acc) begin
            r_mem_q <= r_line[r_col];
        end
    end

    // Forward the word written in the same cycle as a read of that column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_v <= 1'b0;
        end else if (in_acc) begin
            r_byp_v <= s1_out && s1_is_sample && (r_s1_colidx == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byp_word <= s1_new_word;
        end
    end

    // Column of the newest rows and the updated memory word.
    always_comb begin
        s1_word = r_byp_v ? r_byp_word : r_mem_q;
        s1_new_word = '0;
        s1_new_word[SB-1:0] = r_s1_sample;
        for (int l = 1; l < LS; l++) begin
            s1_new_word[l*SB +: SB] = s1_word[(l-1)*SB +: SB];
        end
        s1_colv[K-1] = r_s1_sample;
        for (int i = 1; i < K; i++) begin
            s1_colv[K-1-i] = signed'(s1_word[(i-1)*SB +: SB]);
        end
    end

    // Window shift by one column per sample.
    always_ff @(posedge i_clk) begin
        if (s1_out && s1_is_sample) begin
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][K-1] <= s1_colv[i];
            end
        end
    end

    // Kernel weight store, written at the transaction's weight index when it is below K*K.
    always_ff @(posedge i_clk) begin
        if (s1_out && !s1_is_sample && (32'(r_s1_widx) < 32'(KN))) begin
            r_kern[KIW'(r_s1_widx)] <= r_s1_wval;
        end
    end

    // Weight for each window position under the current kernel geometry.
    always_comb begin
        int i_off;
        int j_off;
        for (int p = 0; p < K; p++) begin
            for (int q = 0; q < K; q++) begin
                i_off = p - (K - int'(r_kh_eff));
                j_off = q - (K - int'(r_kw_eff));
                if (i_off >= 0 && j_off >= 0) begin
                    n_lane[p][q] = r_kern[KIW'(i_off * int'(r_kw_eff) + j_off)];
                end else begin
                    n_lane[p][q] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    // Stage valids; only completed windows continue past stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ld2) r_v2 <= r_v1 && r_s1_emit && s1_is_sample;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
            if (ldo) r_vo <= r_v5;
        end
    end

    // Row sums and the total with the partial sum.
    always_comb begin
        for (int p = 0; p < K; p++) begin
            n_rsum[p] = '0;
            for (int q = 0; q < K; q++) begin
                n_rsum[p] = n_rsum[p] + RW'(r_prod[p][q]);
            end
        end
        n_total = AW'(r_s4_meta.psum);
        for (int p = 0; p < K; p++) begin
            n_total = n_total + AW'(r_rsum[p]);
        end
    end

    // Saturation to the 48-bit result range.
    always_comb begin
        if (r_total > AW'(c2dvw_pkg::ACC_MAX)) begin
            n_o_value = c2dvw_pkg::ACC_MAX;
        end else if (r_total < AW'(c2dvw_pkg::ACC_MIN)) begin
            n_o_value = c2dvw_pkg::ACC_MIN;
        end else begin
            n_o_value = r_total[c2dvw_pkg::ACC_BITS-1:0];
        end
    end

    // Datapath registers of stages 2 to 5 and the output.
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_s2_meta <= r_s1_meta;
        end
        if (ld3) begin
            for (int p = 0; p < K; p++) begin
                for (int q = 0; q < K; q++) begin
                    r_prod[p][q] <= r_win[p][q] * r_lane[p][q];
                end
            end
            r_s3_meta <= r_s2_meta;
        end
        if (ld4) begin
            r_rsum    <= n_rsum;
            r_s4_meta <= r_s3_meta;
        end
        if (ld5) begin
            r_total   <= n_total;
            r_s5_meta <= r_s4_meta;
        end
        if (ldo) begin
            r_o_value <= n_o_value;
            r_o_meta  <= r_s5_meta;
        end
    end

    assign o_out.valid     = r_vo;
    assign o_out.out_value = r_o_value;
    assign o_out.out_row   = r_o_meta.row;
    assign o_out.out_col   = r_o_meta.col;
    assign o_out.last      = r_o_meta.last;

    // Stream position stays inside the tile geometry.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(r_w_eff))
        else $error("column counter beyond row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < 32'(r_h_eff))
        else $error("row counter beyond tile height");

    // The final sample of a tile returns the position to the origin.
    a_tile_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sample_acc && acc_last) |=> (r_row == '0 && r_col == '0))
        else $error("tile did not wrap after its last sample");

    // A result only appears after passing the final sum stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_v5))
        else $error("result valid without a summed window");

endmodule
